@@ rtl/i2cm_pkg.sv @@
// Shared types and constants of the I2C master bit engine.
// Holds the transfer structs for the tick and result channels and the command codes.
// No dependencies.
package i2cm_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned TpuWidth   = 16;
  localparam int unsigned ToWidth    = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned BitCntW    = 4;
  // widest delay product: four units of the largest tick count
  localparam int unsigned ProdWidth  = TpuWidth + 2;

  localparam logic [CfgIdxW-1:0] CfgTicksPerUs = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAckTimeout = 2'd1;

  localparam logic [TpuWidth-1:0] TpuReset     = 16'd1;
  localparam logic [ToWidth-1:0]  TimeoutReset = 8'd250;

  localparam logic [2:0] OpStart = 3'd0;
  localparam logic [2:0] OpStop  = 3'd1;
  localparam logic [2:0] OpSend  = 3'd2;
  localparam logic [2:0] OpWait  = 3'd3;
  localparam logic [2:0] OpRead  = 3'd4;

  typedef struct packed {
    logic                cmd_valid;
    logic [2:0]          opcode;
    logic [ByteBits-1:0] tx_byte;
    logic                ack_after_read;
    logic                sda_sample;
  } tick_t;

  typedef struct packed {
    logic                scl_level;
    logic                sda_drive_en;
    logic                sda_level;
    logic                busy_res;
    logic                done_res;
    logic [ByteBits-1:0] rx_byte;
    logic                ack_error;
  } result_t;

endpackage

@@ rtl/i2c_master_bit_engine_unit.sv @@
// Top level of the I2C master bit engine: configuration registers, tick channel,
// result register. Depends on i2cm_pkg and i2cm_core.
//
// Each transfer on the tick channel is one tick of bus time and yields exactly one
// transfer on the result channel, carrying the SCL/SDA drive state after that tick,
// busy/done flags, the last received byte and the ack timeout flag. The engine takes
// one tick per cycle unless stalled; each result enters the result register as its
// tick is taken. Ticks are taken whenever the result register is empty or is being
// drained in the same cycle, so a stalled consumer holds off the tick channel, but
// never more than that one register. Bus segment lengths are whole multiples of
// ticks_per_us (zero counts as one); segments longer than the TIMER_WIDTH-bit delay
// timer saturate. Commands offered while a command is in progress are dropped.
// Write configuration only while the engine is idle.
module i2c_master_bit_engine_unit #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  i2cm_pkg::tick_t                 in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output i2cm_pkg::result_t               out_data_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [i2cm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [i2cm_pkg::TpuWidth-1:0] tpu_q;
  logic [i2cm_pkg::ToWidth-1:0]  timeout_q;
  logic                          out_valid_q;
  i2cm_pkg::result_t             out_data_q;
  i2cm_pkg::result_t             res;
  logic                          step;

  // configuration writes are always taken; unknown indexes drop
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q     <= i2cm_pkg::TpuReset;
      timeout_q <= i2cm_pkg::TimeoutReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == i2cm_pkg::CfgTicksPerUs) begin
        tpu_q <= cfg_data_i[i2cm_pkg::TpuWidth-1:0];
      end else if (cfg_index_i == i2cm_pkg::CfgAckTimeout) begin
        timeout_q <= cfg_data_i[i2cm_pkg::ToWidth-1:0];
      end
    end
  end

  // advance the engine when the result register can take the new result
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  i2cm_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_data_i),
    .ticks_per_us_i (tpu_q),
    .ack_timeout_i  (timeout_q),
    .res_o          (res)
  );

  // result register: load on each taken tick, drop the valid once drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/i2cm_core.sv @@
// Bit-level sequencer of the I2C master: phase register, delay timer, shifter.
// Computes the result of one tick combinationally and updates state on step_i.
// Depends on i2cm_pkg.
module i2cm_core #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  i2cm_pkg::tick_t                   item_i,
  input  logic [i2cm_pkg::TpuWidth-1:0]     ticks_per_us_i,
  input  logic [i2cm_pkg::ToWidth-1:0]      ack_timeout_i,
  output i2cm_pkg::result_t                 res_o
);

  localparam logic [4:0] PhIdle = 5'd0;
  localparam logic [4:0] PhStA  = 5'd1;
  localparam logic [4:0] PhStB  = 5'd2;
  localparam logic [4:0] PhSpA  = 5'd3;
  localparam logic [4:0] PhSpB  = 5'd4;
  localparam logic [4:0] PhWaA  = 5'd5;
  localparam logic [4:0] PhWaB  = 5'd6;
  localparam logic [4:0] PhPoll = 5'd7;
  localparam logic [4:0] PhEpA  = 5'd8;
  localparam logic [4:0] PhEpB  = 5'd9;
  localparam logic [4:0] PhTxA  = 5'd10;
  localparam logic [4:0] PhTxB  = 5'd11;
  localparam logic [4:0] PhTxC  = 5'd12;
  localparam logic [4:0] PhRxA  = 5'd13;
  localparam logic [4:0] PhRxB  = 5'd14;
  localparam logic [4:0] PhAkA  = 5'd15;
  localparam logic [4:0] PhAkB  = 5'd16;

  localparam int unsigned PW = i2cm_pkg::ProdWidth;
  localparam int unsigned MW = (PW > TIMER_WIDTH) ? PW : TIMER_WIDTH;
  localparam int unsigned BB = i2cm_pkg::ByteBits;

  logic [4:0]                      phase_q, phase_d;
  logic [i2cm_pkg::BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [BB-1:0]                   shift_q, shift_d;
  logic [TIMER_WIDTH-1:0]          timer_q, timer_d;
  logic [i2cm_pkg::ToWidth-1:0]    poll_q, poll_d;
  logic                            ack_mode_q, ack_mode_d;
  logic                            scl_q, scl_d;
  logic                            sda_q, sda_d;
  logic                            oe_q, oe_d;
  logic [BB-1:0]                   rx_hold_q, rx_hold_d;

  logic                            ent;
  logic [4:0]                      ent_ph;
  logic [1:0]                      unit_sh;
  logic [i2cm_pkg::TpuWidth-1:0]   tpu;
  logic [PW-1:0]                   prod;
  logic [MW-1:0]                   load_ext;
  logic [MW-1:0]                   tmr_max;
  logic [TIMER_WIDTH-1:0]          load_val;
  logic                            done;
  logic                            err;

  // delay length of the segment being entered, in ticks minus one, saturated
  always_comb begin
    tpu      = (ticks_per_us_i == '0) ? i2cm_pkg::TpuWidth'(1) : ticks_per_us_i;
    prod     = PW'(tpu) << unit_sh;
    load_ext = MW'(prod - PW'(1));
    tmr_max  = MW'({TIMER_WIDTH{1'b1}});
    load_val = (load_ext > tmr_max) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(load_ext);
  end

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    timer_d    = timer_q;
    poll_d     = poll_q;
    ack_mode_d = ack_mode_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    oe_d       = oe_q;
    rx_hold_d  = rx_hold_q;
    ent        = 1'b0;
    ent_ph     = PhIdle;
    unit_sh    = 2'd1;
    done       = 1'b0;
    err        = 1'b0;

    if (phase_q == PhIdle) begin
      if (item_i.cmd_valid) begin
        unique case (item_i.opcode)
          i2cm_pkg::OpStart: begin
            ent = 1'b1; ent_ph = PhStA;
          end
          i2cm_pkg::OpStop: begin
            ent = 1'b1; ent_ph = PhSpA;
          end
          i2cm_pkg::OpSend: begin
            shift_d = item_i.tx_byte; bit_cnt_d = '0;
            ent = 1'b1; ent_ph = PhTxA;
          end
          i2cm_pkg::OpWait: begin
            poll_d = '0; ent = 1'b1; ent_ph = PhWaA;
          end
          i2cm_pkg::OpRead: begin
            shift_d = '0; bit_cnt_d = '0; ack_mode_d = item_i.ack_after_read;
            ent = 1'b1; ent_ph = PhRxA;
          end
          default: ;
        endcase
      end
    end else if (phase_q == PhPoll) begin
      if (!item_i.sda_sample) begin
        scl_d = 1'b0; phase_d = PhIdle; done = 1'b1;
      end else if (poll_q == ack_timeout_i) begin
        ent = 1'b1; ent_ph = PhEpA;
      end else begin
        poll_d = poll_q + 1'b1;
      end
    end else if (timer_q != '0) begin
      timer_d = timer_q - 1'b1;
    end else begin
      bit_cnt_d = bit_cnt_q + 1'b1;
      unique case (phase_q)
        PhStA: begin ent = 1'b1; ent_ph = PhStB; bit_cnt_d = bit_cnt_q; end
        PhStB: begin scl_d = 1'b0; phase_d = PhIdle; done = 1'b1; bit_cnt_d = bit_cnt_q; end
        PhSpA: begin ent = 1'b1; ent_ph = PhSpB; bit_cnt_d = bit_cnt_q; end
        PhSpB: begin phase_d = PhIdle; done = 1'b1; bit_cnt_d = bit_cnt_q; end
        PhWaA: begin ent = 1'b1; ent_ph = PhWaB; bit_cnt_d = bit_cnt_q; end
        PhWaB: begin phase_d = PhPoll; bit_cnt_d = bit_cnt_q; end
        PhEpA: begin ent = 1'b1; ent_ph = PhEpB; bit_cnt_d = bit_cnt_q; end
        PhEpB: begin
          phase_d = PhIdle; done = 1'b1; err = 1'b1; bit_cnt_d = bit_cnt_q;
        end
        PhTxA: begin ent = 1'b1; ent_ph = PhTxB; bit_cnt_d = bit_cnt_q; end
        PhTxB: begin ent = 1'b1; ent_ph = PhTxC; bit_cnt_d = bit_cnt_q; end
        PhTxC: begin
          if (bit_cnt_d >= i2cm_pkg::BitCntW'(BB)) begin
            phase_d = PhIdle; done = 1'b1;
          end else begin
            ent = 1'b1; ent_ph = PhTxA;
          end
        end
        PhRxA: begin
          // sample on the tick SCL rises
          shift_d = {shift_q[BB-2:0], item_i.sda_sample};
          ent = 1'b1; ent_ph = PhRxB; bit_cnt_d = bit_cnt_q;
        end
        PhRxB: begin
          if (bit_cnt_d >= i2cm_pkg::BitCntW'(BB)) begin
            rx_hold_d = shift_q; ent = 1'b1; ent_ph = PhAkA;
          end else begin
            ent = 1'b1; ent_ph = PhRxA;
          end
        end
        PhAkA: begin ent = 1'b1; ent_ph = PhAkB; bit_cnt_d = bit_cnt_q; end
        PhAkB: begin scl_d = 1'b0; phase_d = PhIdle; done = 1'b1; bit_cnt_d = bit_cnt_q; end
        default: begin phase_d = PhIdle; bit_cnt_d = bit_cnt_q; end
      endcase
    end

    // enter the next segment: set pins and reload the timer
    if (ent) begin
      phase_d = ent_ph;
      unique case (ent_ph)
        PhStA: begin oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; unit_sh = 2'd2; end
        PhStB: begin sda_d = 1'b0; unit_sh = 2'd2; end
        PhSpA, PhEpA: begin oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; unit_sh = 2'd2; end
        PhSpB, PhEpB: begin scl_d = 1'b1; sda_d = 1'b1; unit_sh = 2'd2; end
        PhWaA: begin oe_d = 1'b0; sda_d = 1'b1; unit_sh = 2'd0; end
        PhWaB: begin scl_d = 1'b1; unit_sh = 2'd0; end
        PhTxA: begin
          oe_d = 1'b1; scl_d = 1'b0;
          sda_d   = shift_d[BB-1];
          shift_d = {shift_d[BB-2:0], 1'b0};
        end
        PhTxB: scl_d = 1'b1;
        PhTxC: scl_d = 1'b0;
        PhRxA: begin oe_d = 1'b0; scl_d = 1'b0; end
        PhRxB: begin scl_d = 1'b1; unit_sh = 2'd0; end
        PhAkA: begin scl_d = 1'b0; oe_d = 1'b1; sda_d = ~ack_mode_d; end
        PhAkB: scl_d = 1'b1;
        default: phase_d = PhIdle;
      endcase
      timer_d = load_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      timer_q    <= '0;
      poll_q     <= '0;
      ack_mode_q <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      oe_q       <= 1'b1;
      rx_hold_q  <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      timer_q    <= timer_d;
      poll_q     <= poll_d;
      ack_mode_q <= ack_mode_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      oe_q       <= oe_d;
      rx_hold_q  <= rx_hold_d;
    end
  end

  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_drive_en = oe_d;
    res_o.sda_level    = sda_d;
    res_o.busy_res     = (phase_d != PhIdle);
    res_o.done_res     = done;
    res_o.rx_byte      = rx_hold_d;
    res_o.ack_error    = err;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench of the I2C master bit engine: feeds bus ticks and commands, predicts the
// driven SCL/SDA state of every tick and checks each result transfer against it.
// Depends on i2cm_pkg and i2c_master_bit_engine_unit.
module tb;
  import i2cm_pkg::*;

  localparam int unsigned TimerW = 20;
  localparam longint unsigned TimerMax = (64'd1 << TimerW) - 1;
  // generous cap on the whole run, in ns
  localparam longint LimitNs = 64'd20_000_000;
  localparam int unsigned RandomTicks = 600;
  localparam int unsigned ReportMax = 10;
  // index values that map to no register
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  // bus segments of the engine
  typedef enum logic [4:0] {
    BusIdle, StartHigh, StartLow, StopLow, StopHigh, WaitRelease, WaitSclHigh, WaitPoll,
    AbortLow, AbortHigh, SendSetup, SendHigh, SendLow, RecvLow, RecvHigh, AckDrive, AckHigh
  } seg_e;

  // registers plus the whole engine state
  typedef struct {
    logic [TpuWidth-1:0] tpu;
    logic [ToWidth-1:0]  timeout;
    seg_e                seg;
    logic [BitCntW-1:0]  bits_done;
    logic [ByteBits-1:0] shifter;
    logic [TimerW-1:0]   countdown;
    logic [7:0]          polls;
    logic                ack_low;
    logic                scl;
    logic                sda;
    logic                sda_oe;
    logic [ByteBits-1:0] rx_last;
  } engine_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic    in_valid = 1'b0;
  logic    in_ready;
  tick_t   in_data = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  tick_t   pending_ticks[$];   // ticks waiting for the driver
  result_t awaited_bus[$];     // predicted bus state, oldest first
  engine_t plan;               // engine as of the last queued tick
  engine_t live;               // engine as of the last accepted tick
  bit          no_idle = 1'b0; // both sides run without gaps while set
  bit          tick_taken = 1'b0;
  int unsigned send_pause = 0;
  int unsigned drain_pause = 0;
  int unsigned planned_ticks = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  i2c_master_bit_engine_unit #(.TIMER_WIDTH(TimerW)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Engine prediction
  // ---------------------------------------------------------------------------

  function automatic engine_t engine_at_reset();
    engine_t e;
    e.tpu       = TpuReset;
    e.timeout   = TimeoutReset;
    e.seg       = BusIdle;
    e.bits_done = '0;
    e.shifter   = '0;
    e.countdown = '0;
    e.polls     = '0;
    e.ack_low   = 1'b0;
    e.scl       = 1'b1;
    e.sda       = 1'b1;
    e.sda_oe    = 1'b1;
    e.rx_last   = '0;
    return e;
  endfunction

  // Load the segment timer with units * ticks_per_us - 1; zero ticks count as one,
  // and a span beyond the timer saturates at its top value.
  function automatic void load_countdown(inout engine_t e, input int unsigned units);
    longint unsigned tpu;
    longint unsigned span;
    tpu = (e.tpu == '0) ? 64'd1 : {48'd0, e.tpu};
    span = units * tpu - 64'd1;
    if (span > TimerMax) span = TimerMax;
    e.countdown = span[TimerW-1:0];
  endfunction

  // Enter a segment: set its pin values and start its timer.
  function automatic void enter_seg(inout engine_t e, input seg_e s);
    int unsigned units;
    units = 2;
    e.seg = s;
    case (s)
      StartHigh: begin
        e.sda_oe = 1'b1; e.sda = 1'b1; e.scl = 1'b1; units = 4;
      end
      StartLow: begin
        e.sda = 1'b0; units = 4;
      end
      StopLow, AbortLow: begin
        e.sda_oe = 1'b1; e.scl = 1'b0; e.sda = 1'b0; units = 4;
      end
      StopHigh, AbortHigh: begin
        e.scl = 1'b1; e.sda = 1'b1; units = 4;
      end
      WaitRelease: begin
        e.sda_oe = 1'b0; e.sda = 1'b1; units = 1;
      end
      WaitSclHigh: begin
        e.scl = 1'b1; units = 1;
      end
      SendSetup: begin
        e.sda_oe = 1'b1; e.scl = 1'b0;
        e.sda = e.shifter[ByteBits-1];
        e.shifter = {e.shifter[ByteBits-2:0], 1'b0};
      end
      SendHigh: e.scl = 1'b1;
      SendLow:  e.scl = 1'b0;
      RecvLow: begin
        e.sda_oe = 1'b0; e.scl = 1'b0;
      end
      RecvHigh: begin
        e.scl = 1'b1; units = 1;
      end
      AckDrive: begin
        e.scl = 1'b0; e.sda_oe = 1'b1; e.sda = ~e.ack_low;
      end
      AckHigh:  e.scl = 1'b1;
      default:  e.seg = BusIdle;
    endcase
    load_countdown(e, units);
  endfunction

  // Advance the engine by one tick and give the bus state after it.
  function automatic void advance_engine(inout engine_t e, input tick_t t, output result_t r);
    logic done;
    logic fail;
    done = 1'b0;
    fail = 1'b0;
    if (e.seg == BusIdle) begin
      if (t.cmd_valid) begin
        case (t.opcode)
          OpStart: enter_seg(e, StartHigh);
          OpStop:  enter_seg(e, StopLow);
          OpSend: begin
            e.shifter = t.tx_byte; e.bits_done = '0; enter_seg(e, SendSetup);
          end
          OpWait: begin
            e.polls = '0; enter_seg(e, WaitRelease);
          end
          OpRead: begin
            e.shifter = '0; e.bits_done = '0; e.ack_low = t.ack_after_read;
            enter_seg(e, RecvLow);
          end
          default: ;
        endcase
      end
    end else if (e.seg == WaitPoll) begin
      // one poll per tick with SCL high; a low line ends the wait at once
      if (!t.sda_sample) begin
        e.scl = 1'b0; e.seg = BusIdle; done = 1'b1;
      end else if (e.polls == e.timeout) begin
        enter_seg(e, AbortLow);
      end else begin
        e.polls = e.polls + 8'd1;
      end
    end else if (e.countdown != '0) begin
      e.countdown = e.countdown - 1'b1;
    end else begin
      case (e.seg)
        StartHigh:   enter_seg(e, StartLow);
        StartLow: begin
          e.scl = 1'b0; e.seg = BusIdle; done = 1'b1;
        end
        StopLow:     enter_seg(e, StopHigh);
        StopHigh: begin
          e.seg = BusIdle; done = 1'b1;
        end
        WaitRelease: enter_seg(e, WaitSclHigh);
        WaitSclHigh: e.seg = WaitPoll;
        AbortLow:    enter_seg(e, AbortHigh);
        AbortHigh: begin
          e.seg = BusIdle; done = 1'b1; fail = 1'b1;
        end
        SendSetup:   enter_seg(e, SendHigh);
        SendHigh:    enter_seg(e, SendLow);
        SendLow: begin
          e.bits_done = e.bits_done + 4'd1;
          if (e.bits_done >= ByteBits) begin
            e.seg = BusIdle; done = 1'b1;
          end else begin
            enter_seg(e, SendSetup);
          end
        end
        RecvLow: begin
          // sample on the tick SCL rises
          enter_seg(e, RecvHigh);
          e.shifter = {e.shifter[ByteBits-2:0], t.sda_sample};
        end
        RecvHigh: begin
          e.bits_done = e.bits_done + 4'd1;
          if (e.bits_done >= ByteBits) begin
            e.rx_last = e.shifter;
            enter_seg(e, AckDrive);
          end else begin
            enter_seg(e, RecvLow);
          end
        end
        AckDrive:    enter_seg(e, AckHigh);
        AckHigh: begin
          e.scl = 1'b0; e.seg = BusIdle; done = 1'b1;
        end
        default:     e.seg = BusIdle;
      endcase
    end
    r.scl_level    = e.scl;
    r.sda_drive_en = e.sda_oe;
    r.sda_level    = e.sda;
    r.busy_res     = (e.seg != BusIdle);
    r.done_res     = done;
    r.rx_byte      = e.rx_last;
    r.ack_error    = fail;
  endfunction

  function automatic void apply_reg(inout engine_t e, input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    if (idx == CfgTicksPerUs) e.tpu = val;
    else if (idx == CfgAckTimeout) e.timeout = val[ToWidth-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building: every queued tick also runs through the plan copy, so the
  // generator knows when a command has finished and can shape the next one.
  // ---------------------------------------------------------------------------

  // Mostly short pauses, a few long ones.
  function automatic int unsigned draw_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // SDA low with the given odds in percent
  function automatic logic pick_sda(int unsigned low_pct);
    return ($urandom_range(0, 99) >= low_pct);
  endfunction

  // Odds that the target pulls SDA low on a poll, from prompt to never.
  function automatic int unsigned ack_odds();
    case ($urandom_range(0, 3))
      0:       return 100;
      1:       return 40;
      2:       return 5;
      default: return 0;
    endcase
  endfunction

  function automatic void queue_tick(tick_t t);
    result_t unused;
    advance_engine(plan, t, unused);
    pending_ticks.push_back(t);
    planned_ticks++;
  endfunction

  function automatic tick_t random_tick(logic offer, int unsigned low_pct);
    tick_t t;
    t.cmd_valid      = offer;
    t.opcode         = 3'($urandom_range(0, 7));
    t.tx_byte        = 8'($urandom);
    t.ack_after_read = 1'($urandom);
    t.sda_sample     = pick_sda(low_pct);
    return t;
  endfunction

  function automatic void idle_ticks(int unsigned n);
    repeat (n) queue_tick(random_tick(1'b0, 50));
  endfunction

  // Offer one command, then tick until the engine is idle again. Some ticks while
  // busy carry a stray command, which the engine must drop.
  function automatic void issue(logic [2:0] op, logic [ByteBits-1:0] data, logic ack_bit,
                                int unsigned low_pct);
    tick_t t;
    t = random_tick(1'b1, low_pct);
    t.opcode = op;
    t.tx_byte = data;
    t.ack_after_read = ack_bit;
    queue_tick(t);
    while (plan.seg != BusIdle) queue_tick(random_tick($urandom_range(0, 4) == 0, low_pct));
  endfunction

  // Start, address byte, ack, a few data bytes either way, stop.
  function automatic void run_transaction();
    issue(OpStart, 8'($urandom), 1'($urandom), 50);
    issue(OpSend, 8'($urandom), 1'($urandom), 50);
    issue(OpWait, 8'($urandom), 1'($urandom), ack_odds());
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1) == 0) begin
        issue(OpSend, 8'($urandom), 1'($urandom), 50);
        issue(OpWait, 8'($urandom), 1'($urandom), ack_odds());
      end else begin
        issue(OpRead, 8'($urandom), 1'($urandom), 50);
      end
      idle_ticks($urandom_range(0, 2));
    end
    issue(OpStop, 8'($urandom), 1'($urandom), 50);
  endfunction

  // Hold until every tick is accepted and every result drained, then let the
  // engine settle.
  task automatic wait_quiet();
    while (pending_ticks.size() != 0 || in_valid || awaited_bus.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One transfer on the configuration channel; the register takes effect in both
  // engine copies at the edge that accepts it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    apply_reg(live, idx, val);
    apply_reg(plan, idx, val);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [CfgDataW-1:0] tpu, logic [CfgDataW-1:0] timeout_word,
                            bit steady);
    wait_quiet();
    write_reg(CfgTicksPerUs, tpu);
    write_reg(CfgAckTimeout, timeout_word);
    no_idle = steady;
  endtask

  // ---------------------------------------------------------------------------
  // Tick driver: take the accepted transfer into the live engine at the rising
  // edge, offer the next tick at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t predicted;
    tick_taken = in_valid && in_ready;
    if (tick_taken) begin
      advance_engine(live, in_data, predicted);
      awaited_bus.push_back(predicted);
    end
  end

  always @(negedge clk_i) begin
    // hold valid and payload until the transfer happens
    if (rst_ni && (!in_valid || tick_taken)) begin
      if (send_pause != 0) begin
        in_valid <= 1'b0;
        send_pause <= send_pause - 1;
      end else if (pending_ticks.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_ticks.pop_front();
        send_pause <= no_idle ? 0 : draw_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each result transfer with the oldest prediction,
  // and stall the result channel now and then.
  // ---------------------------------------------------------------------------
  function automatic string show(result_t r);
    return $sformatf("scl=%0b oe=%0b sda=%0b busy=%0b done=%0b rx=%02h err=%0b",
                     r.scl_level, r.sda_drive_en, r.sda_level, r.busy_res, r.done_res,
                     r.rx_byte, r.ack_error);
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= ReportMax) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (out_valid && out_ready) begin
      results_seen++;
      if (awaited_bus.size() == 0) begin
        flag_error($sformatf("result %0d arrived with none expected: %s",
                             results_seen, show(out_data)));
      end else begin
        want = awaited_bus.pop_front();
        if (out_data.scl_level !== want.scl_level || out_data.sda_drive_en !== want.sda_drive_en ||
            out_data.sda_level !== want.sda_level || out_data.busy_res !== want.busy_res ||
            out_data.done_res !== want.done_res || out_data.rx_byte !== want.rx_byte ||
            out_data.ack_error !== want.ack_error) begin
          flag_error($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                               results_seen, show(want), show(out_data)));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drain_pause != 0) begin
        out_ready <= 1'b0;
        drain_pause <= drain_pause - 1;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) drain_pause <= draw_pause();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    live = engine_at_reset();
    plan = engine_at_reset();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, first on the reset register values.
    idle_ticks(3);
    issue(OpStart, 8'h00, 1'b0, 50);
    issue(OpSend, 8'hFF, 1'b0, 50);
    issue(OpWait, 8'h00, 1'b0, 100);      // acked on the first poll
    issue(OpSend, 8'h00, 1'b1, 50);
    issue(OpWait, 8'h00, 1'b0, 10);       // ack after a few high polls
    issue(OpRead, 8'h00, 1'b1, 50);       // random byte, then ACK
    issue(OpRead, 8'hFF, 1'b0, 0);        // all ones, then NACK
    issue(OpRead, 8'h00, 1'b1, 100);      // all zeros
    issue(OpStop, 8'h00, 1'b0, 50);
    // undefined opcodes leave the engine idle
    issue(OpRead + 3'd1, 8'hA5, 1'b1, 50);
    issue(OpRead + 3'd2, 8'h5A, 1'b0, 50);
    issue(OpRead + 3'd3, 8'hC3, 1'b1, 50);

    // zero tick count acts as one; zero timeout fails on the first high poll
    set_config(16'd0, 16'd0, 1'b0);
    issue(OpStart, 8'h00, 1'b0, 50);
    issue(OpWait, 8'h00, 1'b0, 0);
    issue(OpWait, 8'h00, 1'b0, 100);
    issue(OpSend, 8'h81, 1'b0, 50);

    // writes to unmapped indexes must change nothing
    wait_quiet();
    write_reg(CfgSpareA, 16'($urandom));
    write_reg(CfgSpareB, 16'($urandom));
    issue(OpWait, 8'h00, 1'b0, 0);

    // longest timeout with the line stuck high, upper data bits set
    set_config(16'd3, 16'hA5FF, 1'b0);
    issue(OpWait, 8'h00, 1'b0, 0);
    issue(OpRead, 8'h00, 1'b0, 50);
    issue(OpStop, 8'h00, 1'b0, 50);

    // tick count in the upper byte, kept to one short command without gaps
    set_config(16'h0100, 16'd250, 1'b1);
    issue(OpWait, 8'h00, 1'b0, 100);

    // Random part: mostly complete transactions, some loose commands.
    planned_ticks = 0;
    while (planned_ticks < RandomTicks) begin
      logic [CfgDataW-1:0] tpu;
      logic [ToWidth-1:0]  limit;
      case ($urandom_range(0, 9))
        0:       tpu = 16'd0;
        1, 2, 3, 4, 5: tpu = 16'd1;
        6, 7, 8: tpu = 16'($urandom_range(2, 4));
        default: tpu = 16'($urandom_range(5, 8));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: limit = 8'($urandom_range(0, 3));
        3, 4, 5, 6: limit = 8'($urandom_range(0, 20));
        7, 8:    limit = 8'd255;
        default: limit = 8'($urandom);
      endcase
      set_config(tpu, {8'($urandom), limit}, $urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        if (planned_ticks < RandomTicks) begin
          if ($urandom_range(0, 3) != 0) begin
            run_transaction();
          end else begin
            issue(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), ack_odds());
          end
          idle_ticks($urandom_range(0, 3));
        end
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #(LimitNs);
    $display("simulation failed");
    $finish;
  end

endmodule
